@@ src/gdbd_pkg.sv @@
// gdbd_pkg: field widths, constants, month tables and stage types for the
// Gregorian days-between-dates block. No dependencies.
`default_nettype none

package gdbd_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DAYS_W  = 22;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned LEN_W   = 5;
    localparam int unsigned RCP_W   = 13;
    localparam int unsigned PROD_W  = YEAR_W + RCP_W;
    localparam int unsigned QUOT_W  = 8;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    // x / 100 == (x * 5243) >> 19 for every 14-bit x
    localparam logic [RCP_W-1:0] RECIP_100   = 13'd5243;
    localparam int unsigned      RECIP_SHIFT = 19;
    localparam logic [6:0]       CENTURY     = 7'd100;
    localparam logic [8:0]       DAYS_YEAR   = 9'd365;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    // days before the 1st of the month, in a year that starts in March
    function automatic logic [DOY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] o;
        case (m)
            MON_MAR: o = 9'd0;
            MON_APR: o = 9'd31;
            MON_MAY: o = 9'd61;
            MON_JUN: o = 9'd92;
            MON_JUL: o = 9'd122;
            MON_AUG: o = 9'd153;
            MON_SEP: o = 9'd184;
            MON_OCT: o = 9'd214;
            MON_NOV: o = 9'd245;
            MON_DEC: o = 9'd275;
            MON_JAN: o = 9'd306;
            MON_FEB: o = 9'd337;
            default: o = 9'd0;
        endcase
        return o;
    endfunction

    // month length without the leap day; 0 marks a month that does not exist
    function automatic logic [LEN_W-1:0] month_len_base(input logic [MONTH_W-1:0] m);
        logic [LEN_W-1:0] l;
        case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL,
            MON_AUG, MON_OCT, MON_DEC:           l = 5'd31;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: l = 5'd30;
            MON_FEB:                             l = 5'd28;
            default:                             l = 5'd0;
        endcase
        return l;
    endfunction

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [DAY_W-1:0]  day;
        logic [YEAR_W-1:0] yy;
        logic [DOY_W-1:0]  doy;
        logic [LEN_W-1:0]  base_len;
        logic              feb;
        logic              year_ok;
        logic [PROD_W-1:0] prod_y;
        logic [PROD_W-1:0] prod_yy;
    } t_s1_date;

endpackage

`default_nettype wire

@@ src/gdbd_if.sv @@
// gdbd_if: valid/ready channels for the days-between-dates block.
// Depends on gdbd_pkg for field widths.
`default_nettype none

interface gdbd_in_if;
    import gdbd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [YEAR_W-1:0]    first_year;
    logic [MONTH_W-1:0]   first_month;
    logic [DAY_W-1:0]     first_day;
    logic [YEAR_W-1:0]    second_year;
    logic [MONTH_W-1:0]   second_month;
    logic [DAY_W-1:0]     second_day;
    logic                 incl_end;

    modport source (
        output valid, first_year, first_month, first_day,
               second_year, second_month, second_day, incl_end,
        input  ready
    );
    modport sink (
        input  valid, first_year, first_month, first_day,
               second_year, second_month, second_day, incl_end,
        output ready
    );
endinterface

interface gdbd_out_if;
    import gdbd_pkg::*;
    logic              valid;
    logic              ready;
    logic [DAYS_W-1:0] days_between;
    logic              bad_date;

    modport source (output valid, days_between, bad_date, input ready);
    modport sink   (input valid, days_between, bad_date, output ready);
endinterface

`default_nettype wire

@@ src/gregorian_days_between_dates.sv @@
// gregorian_days_between_dates: absolute day count between two Gregorian dates.
// Depends on gdbd_pkg and the channel interfaces in gdbd_if.sv.
//
// Usage:
//   i_in  carries two dates (year, month, day) and incl_end; a beat is
//         taken when valid and ready are both high.
//   o_out returns days_between and bad_date, one result beat per input beat,
//         in order. bad_date is set, and days_between is 0, when either date
//         is outside years 1..9999, has no such month, or a day of 0 or past
//         the length of its month.
//   An input beat passes through the registered stages in order: stage 1 does
//   the month lookups and the multiplies by the reciprocal of 100, stage 2
//   forms both day numbers and the leap/validity checks, stage 3 takes the
//   absolute difference and holds the result.
//   Throughput is one beat per cycle while o_out.ready stays high.
//   When the receiver holds ready low, each stage still fills as long as it
//   is empty, so up to three beats are taken and held; then i_in.ready drops.
//   Nothing is dropped or repeated across a stall.
//   Reset (i_rst_n low, synchronous) empties all stages; no result is pending.
`default_nettype none

module gregorian_days_between_dates (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gdbd_in_if.sink    i_in,
    gdbd_out_if.source o_out
);
    import gdbd_pkg::*;

    // stage valids and enables
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3 = !r_v3 || o_out.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_in.ready = en1;

    // ---------------- stage 1 ----------------
    t_s1_date n_s1 [2];
    t_s1_date r_s1 [2];
    logic     r_inc1;

    logic [YEAR_W-1:0]  in_y [2];
    logic [MONTH_W-1:0] in_m [2];
    logic [DAY_W-1:0]   in_d [2];

    assign in_y[0] = i_in.first_year;
    assign in_m[0] = i_in.first_month;
    assign in_d[0] = i_in.first_day;
    assign in_y[1] = i_in.second_year;
    assign in_m[1] = i_in.second_month;
    assign in_d[1] = i_in.second_day;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n_s1[k].year     = in_y[k];
            n_s1[k].day      = in_d[k];
            // year counted from March: January and February belong to the prior one
            n_s1[k].yy       = (in_m[k] <= MON_FEB) ? in_y[k] - YEAR_W'(1) : in_y[k];
            n_s1[k].doy      = month_offset(in_m[k]) + DOY_W'(in_d[k]) - DOY_W'(1);
            n_s1[k].base_len = month_len_base(in_m[k]);
            n_s1[k].feb      = (in_m[k] == MON_FEB);
            n_s1[k].year_ok  = (in_y[k] >= YEAR_MIN) && (in_y[k] <= YEAR_MAX);
            n_s1[k].prod_y   = PROD_W'(in_y[k]) * PROD_W'(RECIP_100);
            n_s1[k].prod_yy  = PROD_W'(n_s1[k].yy) * PROD_W'(RECIP_100);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1[0] <= n_s1[0];
            r_s1[1] <= n_s1[1];
            r_inc1  <= i_in.incl_end;
        end
    end

    // ---------------- stage 2 ----------------
    logic [DAYS_W-1:0] n_dn [2];
    logic              n_ok [2];
    logic [DAYS_W-1:0] r_dn [2];
    logic              r_ok2;
    logic              r_inc2;

    logic [QUOT_W-1:0] q_y  [2];
    logic [QUOT_W-1:0] q_yy [2];
    logic [YEAR_W:0]   cent_y [2];
    logic              leap [2];
    logic [LEN_W-1:0]  mlen [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            q_y[k]    = r_s1[k].prod_y[RECIP_SHIFT +: QUOT_W];
            q_yy[k]   = r_s1[k].prod_yy[RECIP_SHIFT +: QUOT_W];
            cent_y[k] = (YEAR_W+1)'(q_y[k]) * (YEAR_W+1)'(CENTURY);
            // divisible by 100 exactly when y == (y/100)*100; by 400 when also q%4 == 0
            leap[k]   = (r_s1[k].year[1:0] == 2'd0) &&
                        ((cent_y[k] != (YEAR_W+1)'(r_s1[k].year)) || (q_y[k][1:0] == 2'd0));
            mlen[k]   = r_s1[k].base_len + LEN_W'(r_s1[k].feb && leap[k]);
            n_ok[k]   = r_s1[k].year_ok && (r_s1[k].day != '0) && (r_s1[k].day <= mlen[k]);
            n_dn[k]   = DAYS_W'(r_s1[k].yy) * DAYS_W'(DAYS_YEAR)
                      + DAYS_W'(r_s1[k].yy >> 2)
                      - DAYS_W'(q_yy[k])
                      + DAYS_W'(q_yy[k] >> 2)
                      + DAYS_W'(r_s1[k].doy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_dn[0] <= n_dn[0];
            r_dn[1] <= n_dn[1];
            r_ok2   <= n_ok[0] && n_ok[1];
            r_inc2  <= r_inc1;
        end
    end

    // ---------------- stage 3 ----------------
    logic [DAYS_W-1:0] n_days;
    logic [DAYS_W-1:0] diff;
    logic [DAYS_W-1:0] r_days;
    logic              r_bad;

    always_comb begin
        diff   = (r_dn[0] >= r_dn[1]) ? r_dn[0] - r_dn[1] : r_dn[1] - r_dn[0];
        n_days = r_ok2 ? diff + DAYS_W'(r_inc2) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_days <= n_days;
            r_bad  <= !r_ok2;
        end
    end

    assign o_out.valid        = r_v3;
    assign o_out.days_between = r_days;
    assign o_out.bad_date     = r_bad;

endmodule

`default_nettype wire
